// ===== hdl/bds_pkg.sv =====
package bds_pkg;

	localparam int SampleW = 12;
	localparam int DutyW   = 11;
	localparam int LevelW  = 12;
	localparam int IndexW  = 3;
	localparam int PhaseW  = 3;

	localparam int InDataW  = 48;
	localparam int OutDataW = 24;

	localparam logic [IndexW-1:0] REG_TARGET      = 3'd0;
	localparam logic [IndexW-1:0] REG_PHASE_ONE   = 3'd1;
	localparam logic [IndexW-1:0] REG_PHASE_TWO   = 3'd2;
	localparam logic [IndexW-1:0] REG_OVERCURRENT = 3'd3;
	localparam logic [IndexW-1:0] REG_CUTOUT      = 3'd4;

	localparam logic [LevelW-1:0] TARGET_RESET      = 12'd2048;
	localparam logic [LevelW-1:0] PHASE_ONE_RESET   = 12'd1024;
	localparam logic [LevelW-1:0] PHASE_TWO_RESET   = 12'd2048;
	localparam logic [LevelW-1:0] OVERCURRENT_RESET = 12'd3500;
	localparam logic [LevelW-1:0] CUTOUT_RESET      = 12'd1500;

	localparam logic [PhaseW-1:0] PHASES_LOW = 3'b010;
	localparam logic [PhaseW-1:0] PHASES_MID = 3'b101;
	localparam logic [PhaseW-1:0] PHASES_ALL = 3'b111;

	localparam logic OP_REGULATE   = 1'b0;
	localparam logic OP_SOFT_START = 1'b1;

	typedef struct packed {
		logic [LevelW-1:0] target_level;
		logic [LevelW-1:0] phase_one_level;
		logic [LevelW-1:0] phase_two_level;
		logic [LevelW-1:0] overcurrent_level;
		logic [LevelW-1:0] cutout_level;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic [SampleW-1:0] output_sample;
		logic [SampleW-1:0] battery_sample;
		logic [SampleW-1:0] current_sample;
		logic [DutyW-1:0]   duty_ceiling;
	} in_item_t;

	typedef struct packed {
		logic [DutyW-1:0]  compare_value;
		logic              compare_valid;
		logic [PhaseW-1:0] phase_enable;
		logic              keep_starting;
		logic              undervolt;
		logic              overcurrent;
	} res_t;

endpackage

// ===== hdl/buck_duty_stepper_unit.sv =====
// Duty stepper for a three-phase buck converter. Each input item carries the
// output, battery and current samples, a duty ceiling and the mode in tuser;
// it produces exactly one result item with the timer compare value, the phase
// enables and the protection flags. The block takes one item per clock while
// the result side is not stalled. Each result is registered in the result
// register as its item leaves the input register: these two registers bracket
// the step logic, and the stored duty is updated as an item moves from the
// first to the second. Backpressure on the result side holds a waiting result
// and a full input register in place.
module buck_duty_stepper_unit #(
	parameter int PERIOD_COUNTS = 1200
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// output_sample, battery_sample, current_sample, duty_ceiling, zero fill
	input  logic [bds_pkg::InDataW-1:0]   s_tdata,
	// operation
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// compare_value, compare_valid, phase_enable, keep_starting, undervolt,
	// overcurrent, zero fill
	output logic [bds_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [bds_pkg::IndexW-1:0]    cfg_index,
	input  logic [bds_pkg::LevelW-1:0]    cfg_data
);
	import bds_pkg::*;

	cfg_t             cfg;
	in_item_t         item_s1;
	logic             valid_s1;
	res_t             res_s2;
	logic             valid_s2;
	logic [DutyW-1:0] duty_q;
	logic [DutyW-1:0] duty_next;
	res_t             res_next;
	logic             adv_s2;
	logic             adv_s1;
	logic             take;

	bds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bds_calc #(
		.PERIOD_COUNTS (PERIOD_COUNTS)
	) u_calc (
		.cfg       (cfg),
		.item      (item_s1),
		.duty      (duty_q),
		.duty_next (duty_next),
		.res       (res_next)
	);

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			duty_q   <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				duty_q <= duty_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation      <= s_tuser;
			item_s1.output_sample  <= s_tdata[11:0];
			item_s1.battery_sample <= s_tdata[23:12];
			item_s1.current_sample <= s_tdata[35:24];
			item_s1.duty_ceiling   <= s_tdata[46:36];
		end
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, res_s2.overcurrent, res_s2.undervolt, res_s2.keep_starting,
		res_s2.phase_enable, res_s2.compare_valid, res_s2.compare_value};

`ifndef SYNTHESIS
	a_duty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(duty_q))
		else $error("duty changed without an item advancing");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2))
		else $error("input stalled while a register stage is free");

	a_keep_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.keep_starting |-> res_s2.compare_valid)
		else $error("keep_starting without compare_valid");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.phase_enable == PHASES_LOW ||
			res_s2.phase_enable == PHASES_MID || res_s2.phase_enable == PHASES_ALL))
		else $error("illegal phase pattern");

	a_compare_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.compare_value != '0))
		else $error("compare value of zero");
`endif

endmodule

// ===== hdl/bds_cfg.sv =====
module bds_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bds_pkg::IndexW-1:0]   cfg_index,
	input  logic [bds_pkg::LevelW-1:0]   cfg_data,
	output bds_pkg::cfg_t                cfg
);
	import bds_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level      <= TARGET_RESET;
			cfg_q.phase_one_level   <= PHASE_ONE_RESET;
			cfg_q.phase_two_level   <= PHASE_TWO_RESET;
			cfg_q.overcurrent_level <= OVERCURRENT_RESET;
			cfg_q.cutout_level      <= CUTOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET:      cfg_q.target_level      <= cfg_data;
				REG_PHASE_ONE:   cfg_q.phase_one_level   <= cfg_data;
				REG_PHASE_TWO:   cfg_q.phase_two_level   <= cfg_data;
				REG_OVERCURRENT: cfg_q.overcurrent_level <= cfg_data;
				REG_CUTOUT:      cfg_q.cutout_level      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bds_calc.sv =====
module bds_calc #(
	parameter int PERIOD_COUNTS = 1200
) (
	input  bds_pkg::cfg_t                cfg,
	input  bds_pkg::in_item_t            item,
	input  logic [bds_pkg::DutyW-1:0]    duty,
	output logic [bds_pkg::DutyW-1:0]    duty_next,
	output bds_pkg::res_t                res
);
	import bds_pkg::*;

	localparam logic [15:0] TOP = 16'(PERIOD_COUNTS - 1);

	logic             above;
	logic             below;
	logic [DutyW:0]   duty_ext;
	logic [DutyW:0]   limit_ext;
	logic [DutyW:0]   inc;
	logic [DutyW:0]   stepped;
	logic [DutyW:0]   picked;
	logic             valid;
	logic             keep;
	logic [15:0]      cmp_raw;

	assign above     = item.output_sample > cfg.target_level;
	assign below     = item.output_sample < cfg.target_level;
	assign duty_ext  = {1'b0, duty};
	assign limit_ext = {1'b0, item.duty_ceiling};
	assign inc       = duty_ext + 1'b1;

	always_comb begin
		stepped = duty_ext;
		picked  = duty_ext;
		valid   = 1'b0;
		keep    = 1'b0;
		if (item.operation == OP_REGULATE) begin
			if (above) begin
				if (duty != '0) begin
					stepped = duty_ext - 1'b1;
				end
			end else if (below) begin
				stepped = inc;
			end
			picked = (stepped > limit_ext) ? limit_ext : stepped;
			valid  = 1'b1;
		end else if (below) begin
			if (inc > limit_ext) begin
				picked = limit_ext;
			end else begin
				picked = inc;
				valid  = 1'b1;
				keep   = 1'b1;
			end
		end
	end

	assign duty_next = picked[DutyW-1:0];

	always_comb begin
		if (duty_next <= DutyW'(1)) begin
			cmp_raw = 16'd1;
		end else begin
			cmp_raw = 16'(duty_next) - 16'd1;
		end
		if (cmp_raw > TOP) begin
			cmp_raw = TOP;
		end
	end

	always_comb begin
		res.compare_value = cmp_raw[DutyW-1:0];
		res.compare_valid = valid;
		res.keep_starting = keep;
		res.undervolt     = item.battery_sample <= cfg.cutout_level;
		res.overcurrent   = item.current_sample > cfg.overcurrent_level;
		priority if (item.current_sample < cfg.phase_one_level) begin
			res.phase_enable = PHASES_LOW;
		end else if (item.current_sample > cfg.phase_one_level &&
				item.current_sample < cfg.phase_two_level) begin
			res.phase_enable = PHASES_MID;
		end else begin
			res.phase_enable = PHASES_ALL;
		end
	end

endmodule

// ===== test/tb_buck_duty_stepper_unit.sv =====
module tb_buck_duty_stepper_unit;

	import bds_pkg::*;

	localparam int PERIOD      = 1200;
	localparam int SEGMENTS    = 6;
	localparam int SEG_ITEMS   = 334;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FILL_OUT    = OutDataW - DutyW - PhaseW - 4;
	localparam int FILL_IN     = InDataW - 3 * SampleW - DutyW;
	localparam int LEVEL_MAX   = (1 << LevelW) - 1;
	localparam int DUTY_MAX    = (1 << DutyW) - 1;

	typedef struct packed {
		logic [FILL_IN-1:0] fill;
		logic [DutyW-1:0]   duty_ceiling;
		logic [SampleW-1:0] current_sample;
		logic [SampleW-1:0] battery_sample;
		logic [SampleW-1:0] output_sample;
	} s_word_t;

	typedef struct packed {
		logic [FILL_OUT-1:0] fill;
		logic                overcurrent;
		logic                undervolt;
		logic                keep_starting;
		logic [PhaseW-1:0]   phase_enable;
		logic                compare_valid;
		logic [DutyW-1:0]    compare_value;
	} m_word_t;

	class duty_scoreboard;
		cfg_t             regs;
		logic [DutyW-1:0] duty;
		res_t             pending_q[$];
		int               errors;
		int               n_items;
		int               n_results;
		int               n_regulate;
		int               n_valid;
		int               n_keep;
		int               n_top;
		int               peak_duty;

		function new();
			regs.target_level      = TARGET_RESET;
			regs.phase_one_level   = PHASE_ONE_RESET;
			regs.phase_two_level   = PHASE_TWO_RESET;
			regs.overcurrent_level = OVERCURRENT_RESET;
			regs.cutout_level      = CUTOUT_RESET;
			duty = '0;
		endfunction

		function void write_reg(logic [IndexW-1:0] idx, logic [LevelW-1:0] v);
			case (idx)
				REG_TARGET:      regs.target_level = v;
				REG_PHASE_ONE:   regs.phase_one_level = v;
				REG_PHASE_TWO:   regs.phase_two_level = v;
				REG_OVERCURRENT: regs.overcurrent_level = v;
				REG_CUTOUT:      regs.cutout_level = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void note_input(in_item_t it);
			logic [DutyW:0] nxt;
			int             cmp;
			res_t           r;
			nxt = {1'b0, duty};
			r = '0;
			if (it.operation == OP_REGULATE) begin
				if (it.output_sample > regs.target_level) begin
					if (nxt != 0)
						nxt = nxt - 1'b1;
				end else if (it.output_sample < regs.target_level) begin
					nxt = nxt + 1'b1;
				end
				if (nxt > {1'b0, it.duty_ceiling})
					nxt = {1'b0, it.duty_ceiling};
				r.compare_valid = 1'b1;
				n_regulate++;
			end else if (it.output_sample < regs.target_level) begin
				nxt = nxt + 1'b1;
				if (nxt > {1'b0, it.duty_ceiling}) begin
					nxt = {1'b0, it.duty_ceiling};
				end else begin
					r.compare_valid = 1'b1;
					r.keep_starting = 1'b1;
				end
			end
			duty = nxt[DutyW-1:0];
			cmp = (duty <= 1) ? 1 : int'(duty) - 1;
			if (cmp > PERIOD - 1)
				cmp = PERIOD - 1;
			r.compare_value = cmp[DutyW-1:0];
			if (it.current_sample < regs.phase_one_level)
				r.phase_enable = PHASES_LOW;
			else if (it.current_sample > regs.phase_one_level &&
				it.current_sample < regs.phase_two_level)
				r.phase_enable = PHASES_MID;
			else
				r.phase_enable = PHASES_ALL;
			r.undervolt   = it.battery_sample <= regs.cutout_level;
			r.overcurrent = it.current_sample > regs.overcurrent_level;
			pending_q.push_back(r);
			n_items++;
			n_valid += r.compare_valid;
			n_keep += r.keep_starting;
			n_top += (cmp == PERIOD - 1);
			if (int'(duty) > peak_duty)
				peak_duty = int'(duty);
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH result %0d %s: got %0d expected %0d",
				n_results, what, got, want);
			errors++;
		endtask

		task check_result(m_word_t d);
			res_t want;
			n_results++;
			if (pending_q.size() == 0) begin
				report("arrived with nothing pending", d, 0);
				return;
			end
			want = pending_q.pop_front();
			if (d.compare_value != want.compare_value)
				report("compare_value", d.compare_value, want.compare_value);
			if (d.compare_valid != want.compare_valid)
				report("compare_valid", d.compare_valid, want.compare_valid);
			if (d.phase_enable != want.phase_enable)
				report("phase_enable", d.phase_enable, want.phase_enable);
			if (d.keep_starting != want.keep_starting)
				report("keep_starting", d.keep_starting, want.keep_starting);
			if (d.undervolt != want.undervolt)
				report("undervolt", d.undervolt, want.undervolt);
			if (d.overcurrent != want.overcurrent)
				report("overcurrent", d.overcurrent, want.overcurrent);
			if (d.fill != '0)
				report("zero fill", d.fill, 0);
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we;
	logic [IndexW-1:0]   cfg_index;
	logic [LevelW-1:0]   cfg_data;

	duty_scoreboard sb;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             cycle_count = 0;
	int             n_settings = 0;

	buck_duty_stepper_unit #(.PERIOD_COUNTS(PERIOD)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending.", cycle_count,
				sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic int clip(int v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(in_item_t it);
		s_word_t w;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		w.fill           = '0;
		w.duty_ceiling   = it.duty_ceiling;
		w.current_sample = it.current_sample;
		w.battery_sample = it.battery_sample;
		w.output_sample  = it.output_sample;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= it.operation;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic send(logic op, int vout, int batt, int cur, int lim);
		in_item_t it;
		it.operation      = op;
		it.output_sample  = vout[SampleW-1:0];
		it.battery_sample = batt[SampleW-1:0];
		it.current_sample = cur[SampleW-1:0];
		it.duty_ceiling   = lim[DutyW-1:0];
		send_item(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [IndexW-1:0] idx, logic [LevelW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic configure(int seg);
		int tgt, p1, p2, oc, cut;
		tgt = $urandom_range(0, LEVEL_MAX);
		p1  = $urandom_range(0, LEVEL_MAX);
		p2  = $urandom_range(0, LEVEL_MAX);
		oc  = $urandom_range(0, LEVEL_MAX);
		cut = $urandom_range(0, LEVEL_MAX);
		case (seg)
			0: tgt = $urandom_range(1024, 3072);
			1: begin
				tgt = LEVEL_MAX; p1 = 0; p2 = LEVEL_MAX; oc = LEVEL_MAX; cut = 0;
			end
			2: begin
				tgt = 0; p1 = LEVEL_MAX; p2 = 0; oc = 0; cut = LEVEL_MAX;
			end
			3: p2 = $urandom_range(0, p1);
			default: begin
				tgt = $urandom_range(2048, LEVEL_MAX);
				p2  = $urandom_range(p1, LEVEL_MAX);
			end
		endcase
		cfg_write(REG_TARGET, tgt[LevelW-1:0]);
		cfg_write(REG_PHASE_ONE, p1[LevelW-1:0]);
		cfg_write(REG_PHASE_TWO, p2[LevelW-1:0]);
		cfg_write(REG_OVERCURRENT, oc[LevelW-1:0]);
		cfg_write(REG_CUTOUT, cut[LevelW-1:0]);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Most items steer the output sample below the setpoint and pick limits
	// around the stored duty, so the duty climbs far and often meets its clamp.
	function automatic in_item_t make_item(bit wide_limit);
		in_item_t it;
		int       r, tgt, d, v;
		tgt = int'(sb.regs.target_level);
		d   = int'(sb.duty);
		it.operation = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 8)
			v = $urandom_range(0, LEVEL_MAX);
		else if (r < 14)
			v = tgt;
		else if (r < 24)
			v = (tgt < LEVEL_MAX) ? $urandom_range(tgt + 1, LEVEL_MAX) : tgt;
		else
			v = (tgt > 0) ? $urandom_range(0, tgt - 1) : 0;
		it.output_sample = v[SampleW-1:0];
		if ($urandom_range(0, 99) < 30)
			v = clip(int'(sb.regs.cutout_level) + $urandom_range(0, 2) - 1, LEVEL_MAX);
		else
			v = $urandom_range(0, LEVEL_MAX);
		it.battery_sample = v[SampleW-1:0];
		r = $urandom_range(0, 9);
		if (r == 0)
			v = int'(sb.regs.phase_one_level);
		else if (r == 1)
			v = int'(sb.regs.phase_two_level);
		else if (r == 2)
			v = int'(sb.regs.overcurrent_level);
		else
			v = $urandom_range(0, LEVEL_MAX);
		if (r < 3)
			v = clip(v + $urandom_range(0, 2) - 1, LEVEL_MAX);
		it.current_sample = v[SampleW-1:0];
		r = $urandom_range(0, 99);
		if (wide_limit && r < 2)
			v = $urandom_range(0, DUTY_MAX);
		else if (r < 40)
			v = DUTY_MAX;
		else if (r < 70)
			v = d + $urandom_range(0, 3);
		else if (r < 91)
			v = d + $urandom_range(0, 100);
		else
			v = d - $urandom_range(0, 2);
		v = clip(v, DUTY_MAX);
		it.duty_ceiling = v[DutyW-1:0];
		return it;
	endfunction

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Writes to unused indexes must leave every level untouched.
		for (int i = REG_CUTOUT + 1; i < (1 << IndexW); i++)
			cfg_write(i[IndexW-1:0], LevelW'($urandom_range(0, LEVEL_MAX)));
		cfg_we <= 1'b0;

		send_idle_pct = 29;
		recv_idle_pct = 64;
		send(OP_REGULATE, 4095, 0, 0, 0);
		send(OP_REGULATE, 0, 4095, 4095, 2047);
		send(OP_REGULATE, 0, 1500, 1023, 1200);
		send(OP_SOFT_START, 0, 1501, 1024, 1200);
		send(OP_SOFT_START, 2047, 0, 1025, 3);
		send(OP_SOFT_START, 2048, 0, 2047, 1200);
		send(OP_SOFT_START, 4095, 0, 2048, 1200);
		send(OP_REGULATE, 2048, 0, 3500, 1);
		send(OP_REGULATE, 3000, 0, 3501, 1200);
		send(OP_REGULATE, 3000, 4095, 3499, 0);
		send(OP_REGULATE, 'h555, 'hAAA, 'h555, 'h2AA);
		send(OP_SOFT_START, 'hAAA, 'h555, 'hAAA, 'h555);
		send(OP_SOFT_START, 2047, 4095, 0, 2047);
		send(OP_SOFT_START, 0, 0, 4095, 0);
		send(OP_REGULATE, 1, 1499, 2049, 2047);
		send(OP_SOFT_START, 2047, 1500, 1024, 2047);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			send_idle_pct = (seg < 2) ? 29 : (seg < 4) ? 64 : 0;
			recv_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 29 : 0;
			configure(seg);
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if (k == SEG_ITEMS / 3)
					drain();
				send_item(make_item(seg < 2));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("results never arrived", sb.pending(), 0);
		$display("Ran %0d items (%0d regulate) under %0d level settings;",
			sb.n_items, sb.n_regulate, n_settings);
		$display("%0d valid, %0d starting, peak duty %0d, compare at period top %0d times.",
			sb.n_valid, sb.n_keep, sb.peak_duty, sb.n_top);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bds_pkg.sv
hdl/bds_cfg.sv
hdl/bds_calc.sv
hdl/buck_duty_stepper_unit.sv
test/tb_buck_duty_stepper_unit.sv
